// ===== hdl/fps_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package fps_pkg;

    localparam int CMD_W    = 2;
    localparam int IDX_W    = 4;
    localparam int PRI_W    = 8;
    localparam int ST_W     = 3;
    localparam int CNT_W    = 5;
    localparam int POL_W    = 2;
    localparam int CFG_IX_W = 1;
    localparam int CFG_D_W  = 5;
    localparam int IN_W     = 24;
    localparam int OUT_W    = 16;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE   = 2'd0,
        CMD_REBUILD = 2'd1,
        CMD_PUSH    = 2'd2,
        CMD_PICK    = 2'd3
    } t_cmd;

    localparam logic [POL_W-1:0]    POL_PRIORITY = 2'd2;
    localparam logic [ST_W-1:0]     ST_READY     = 3'd1;
    localparam logic [ST_W-1:0]     ST_RUNNING   = 3'd2;
    localparam logic [CFG_IX_W-1:0] CFG_POLICY   = 1'b0;
    localparam logic [CFG_IX_W-1:0] CFG_ACTIVE   = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic write_task;
        logic clear_q;
        logic scan_start;
        logic scan_run;
        logic push;
        logic pop_commit;
        logic best_commit;
        logic out_load;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        t_cmd cmd;
        logic pri_mode;
        logic q_empty;
        logic scan_done;
    } t_dp_sts;

endpackage

`default_nettype wire

// ===== hdl/fifo_priority_task_scheduler.sv =====
// from accept to result, write and push pass dispatch and done, fifo pick passes
// dispatch, pop (when the fifo is not empty) and done, rebuild and priority pick pass
// dispatch, a scan of min(active_tasks, NUM_TASKS) entries and done; one item at a
// time, the next one is taken the cycle after the result is loaded; scans read one entry a cycle
// reset (i_rst_n low, synchronous): tables read as zero, fifo empty,
// policy 0, active_tasks 1, no result pending
`timescale 1ns / 1ps
`default_nettype none

module fifo_priority_task_scheduler #(
    parameter int NUM_TASKS = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    // cmd[1:0], task_index[5:2], task_priority[13:6], task_state[16:14]
    input  wire logic [fps_pkg::IN_W-1:0]          i_s_axis_tdata,
    output logic                                   o_m_axis_tvalid,
    input  wire logic                              i_m_axis_tready,
    // ok[0], result_index[4:1], ready_count[9:5]
    output logic      [fps_pkg::OUT_W-1:0]         o_m_axis_tdata,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [fps_pkg::CFG_IX_W-1:0]      i_cfg_index,
    input  wire logic [fps_pkg::CFG_D_W-1:0]       i_cfg_data
);

    fps_pkg::t_dp_cmd              dp_cmd;
    fps_pkg::t_dp_sts              dp_sts;
    logic                          res_ok;
    logic [fps_pkg::IDX_W-1:0]     res_index;
    logic [fps_pkg::CNT_W-1:0]     res_count;

    assign o_cfg_ready = 1'b1;

    fps_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .o_s_ready (o_s_axis_tready),
        .o_m_valid (o_m_axis_tvalid),
        .i_m_ready (i_m_axis_tready),
        .i_sts     (dp_sts),
        .o_cmd     (dp_cmd)
    );

    fps_datapath #(.NUM_TASKS(NUM_TASKS)) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .o_sts           (dp_sts),
        .i_cmd_code      (i_s_axis_tdata[1:0]),
        .i_task_index    (i_s_axis_tdata[5:2]),
        .i_task_priority (i_s_axis_tdata[13:6]),
        .i_task_state    (i_s_axis_tdata[16:14]),
        .i_cfg_we        (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_ok            (res_ok),
        .o_result_index  (res_index),
        .o_ready_count   (res_count)
    );

    assign o_m_axis_tdata = {6'b0, res_count, res_index, res_ok};

endmodule

`default_nettype wire

// ===== hdl/fps_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== hdl/fps_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fps_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_s_valid,
    output logic                  o_s_ready,
    output logic                  o_m_valid,
    input  wire logic             i_m_ready,
    input  wire fps_pkg::t_dp_sts i_sts,
    output fps_pkg::t_dp_cmd      o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_POP,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_m_valid;
    logic   out_free;

    assign out_free  = !r_m_valid || i_m_ready;
    assign o_s_ready = (r_state == S_IDLE);
    assign o_m_valid = r_m_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_s_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (i_sts.cmd)
                    fps_pkg::CMD_WRITE: begin
                        o_cmd.write_task = 1'b1;
                        n_state          = S_DONE;
                    end
                    fps_pkg::CMD_REBUILD: begin
                        o_cmd.clear_q    = 1'b1;
                        o_cmd.scan_start = 1'b1;
                        n_state          = S_SCAN;
                    end
                    fps_pkg::CMD_PUSH: begin
                        o_cmd.push = 1'b1;
                        n_state    = S_DONE;
                    end
                    default: begin
                        if (i_sts.pri_mode) begin
                            o_cmd.scan_start = 1'b1;
                            n_state          = S_SCAN;
                        end else if (i_sts.q_empty) begin
                            n_state = S_DONE;
                        end else begin
                            // slot at head is read this cycle
                            n_state = S_POP;
                        end
                    end
                endcase
            end
            S_SCAN: begin
                o_cmd.scan_run = 1'b1;
                if (i_sts.scan_done) begin
                    o_cmd.best_commit = (i_sts.cmd == fps_pkg::CMD_PICK);
                    n_state           = S_DONE;
                end
            end
            S_POP: begin
                o_cmd.pop_commit = 1'b1;
                n_state          = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_load) begin
                r_m_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/fps_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fps_datapath #(
    parameter int NUM_TASKS = 16
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire fps_pkg::t_dp_cmd                 i_cmd,
    output fps_pkg::t_dp_sts                      o_sts,
    input  wire logic [fps_pkg::CMD_W-1:0]        i_cmd_code,
    input  wire logic [fps_pkg::IDX_W-1:0]        i_task_index,
    input  wire logic [fps_pkg::PRI_W-1:0]        i_task_priority,
    input  wire logic [fps_pkg::ST_W-1:0]         i_task_state,
    input  wire logic                             i_cfg_we,
    input  wire logic [fps_pkg::CFG_IX_W-1:0]     i_cfg_index,
    input  wire logic [fps_pkg::CFG_D_W-1:0]      i_cfg_data,
    output logic                                  o_ok,
    output logic      [fps_pkg::IDX_W-1:0]        o_result_index,
    output logic      [fps_pkg::CNT_W-1:0]        o_ready_count
);

    localparam int AW = $clog2(NUM_TASKS);
    localparam int CW = $clog2(NUM_TASKS + 1);

    // latched item
    fps_pkg::t_cmd                 r_cmd;
    logic [fps_pkg::IDX_W-1:0]     r_idx;
    logic [fps_pkg::PRI_W-1:0]     r_pri;
    logic [fps_pkg::ST_W-1:0]      r_st;

    logic [fps_pkg::POL_W-1:0]     r_policy;
    logic [fps_pkg::CFG_D_W-1:0]   r_active;

    // ring fifo pointers
    logic [AW-1:0]                 r_head, r_tail;
    logic [CW-1:0]                 r_count;

    // tables reset to zero through per-entry valid bits
    logic [NUM_TASKS-1:0]          r_st_vld, r_pr_vld;

    // scan engine
    logic [CW-1:0]                 r_scan_cnt;
    logic                          r_chk_vld, r_chk_sv, r_chk_pv;
    logic [AW-1:0]                 r_chk_idx;
    logic                          r_found;
    logic [AW-1:0]                 r_best_idx;
    logic [fps_pkg::PRI_W-1:0]     r_best_pri;

    logic                          r_ok;
    logic [AW-1:0]                 r_res;

    logic [CW-1:0]                 lim;
    logic [AW-1:0]                 scan_addr;
    logic                          scan_issue;
    logic [fps_pkg::ST_W-1:0]      st_rdata, chk_st;
    logic [fps_pkg::PRI_W-1:0]     pr_rdata, chk_pr;
    logic [AW-1:0]                 q_rdata;
    logic                          chk_ready, rebuild_push, idx_in_range, push_ok;

    logic                          st_we, pr_we, q_we;
    logic [AW-1:0]                 st_waddr, q_wdata;
    logic [fps_pkg::ST_W-1:0]      st_wdata;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        logic [AW-1:0] r;
        if (p == AW'(NUM_TASKS - 1)) begin
            r = '0;
        end else begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    always_comb begin
        if (32'(r_active) < NUM_TASKS) begin
            lim = CW'(r_active);
        end else begin
            lim = CW'(NUM_TASKS);
        end
    end

    assign scan_addr    = r_scan_cnt[AW-1:0];
    assign scan_issue   = i_cmd.scan_run && (r_scan_cnt < lim);
    assign chk_st       = r_chk_sv ? st_rdata : '0;
    assign chk_pr       = r_chk_pv ? pr_rdata : '0;
    assign chk_ready    = r_chk_vld && (chk_st == fps_pkg::ST_READY);
    assign rebuild_push = i_cmd.scan_run && chk_ready && (r_cmd == fps_pkg::CMD_REBUILD);
    assign idx_in_range = 32'(r_idx) < NUM_TASKS;
    assign push_ok      = idx_in_range && (32'(r_count) < NUM_TASKS);

    always_comb begin
        st_we    = 1'b0;
        st_waddr = AW'(r_idx);
        st_wdata = r_st;
        if (i_cmd.write_task && idx_in_range) begin
            st_we = 1'b1;
        end else if (i_cmd.best_commit && r_found) begin
            st_we    = 1'b1;
            st_waddr = r_best_idx;
            st_wdata = fps_pkg::ST_RUNNING;
        end else if (i_cmd.pop_commit) begin
            st_we    = 1'b1;
            st_waddr = q_rdata;
            st_wdata = fps_pkg::ST_RUNNING;
        end
    end

    assign pr_we   = i_cmd.write_task && idx_in_range;
    assign q_we    = rebuild_push || (i_cmd.push && push_ok);
    assign q_wdata = rebuild_push ? r_chk_idx : AW'(r_idx);

    fps_ram #(.WIDTH(fps_pkg::ST_W), .DEPTH(NUM_TASKS)) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_raddr (scan_addr),
        .o_rdata (st_rdata)
    );

    fps_ram #(.WIDTH(fps_pkg::PRI_W), .DEPTH(NUM_TASKS)) u_prio_ram (
        .i_clk   (i_clk),
        .i_we    (pr_we),
        .i_waddr (AW'(r_idx)),
        .i_wdata (r_pri),
        .i_raddr (scan_addr),
        .o_rdata (pr_rdata)
    );

    fps_ram #(.WIDTH(AW), .DEPTH(NUM_TASKS)) u_queue_ram (
        .i_clk   (i_clk),
        .i_we    (q_we),
        .i_waddr (r_tail),
        .i_wdata (q_wdata),
        .i_raddr (r_head),
        .o_rdata (q_rdata)
    );

    assign o_sts.cmd       = r_cmd;
    assign o_sts.pri_mode  = (r_policy == fps_pkg::POL_PRIORITY);
    assign o_sts.q_empty   = (r_count == '0);
    assign o_sts.scan_done = !r_chk_vld && (r_scan_cnt >= lim);

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd      <= fps_pkg::CMD_WRITE;
            r_policy   <= '0;
            r_active   <= fps_pkg::CFG_D_W'(1);
            r_head     <= '0;
            r_tail     <= '0;
            r_count    <= '0;
            r_st_vld   <= '0;
            r_pr_vld   <= '0;
            r_scan_cnt <= '0;
            r_chk_vld  <= 1'b0;
            r_found    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    fps_pkg::CFG_POLICY: r_policy <= i_cfg_data[fps_pkg::POL_W-1:0];
                    fps_pkg::CFG_ACTIVE: r_active <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.load) begin
                r_cmd <= fps_pkg::t_cmd'(i_cmd_code);
            end
            if (st_we) begin
                r_st_vld[st_waddr] <= 1'b1;
            end
            if (pr_we) begin
                r_pr_vld[AW'(r_idx)] <= 1'b1;
            end

            if (i_cmd.clear_q) begin
                r_head  <= '0;
                r_tail  <= '0;
                r_count <= '0;
            end else if (q_we) begin
                r_tail  <= ptr_inc(r_tail);
                r_count <= r_count + 1'b1;
            end else if (i_cmd.pop_commit) begin
                r_head  <= ptr_inc(r_head);
                r_count <= r_count - 1'b1;
            end

            if (i_cmd.scan_start) begin
                r_scan_cnt <= '0;
                r_chk_vld  <= 1'b0;
                r_found    <= 1'b0;
            end else if (i_cmd.scan_run) begin
                r_chk_vld <= scan_issue;
                if (scan_issue) begin
                    r_scan_cnt <= r_scan_cnt + 1'b1;
                end
                if (chk_ready && (r_cmd == fps_pkg::CMD_PICK)) begin
                    r_found <= 1'b1;
                end
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_idx <= i_task_index;
            r_pri <= i_task_priority;
            r_st  <= i_task_state;
            r_ok  <= 1'b0;
            r_res <= '0;
        end
        if (scan_issue) begin
            r_chk_idx <= scan_addr;
            r_chk_sv  <= r_st_vld[scan_addr];
            r_chk_pv  <= r_pr_vld[scan_addr];
        end
        // strictly higher priority wins, so the lowest index keeps ties
        if (i_cmd.scan_run && chk_ready && (r_cmd == fps_pkg::CMD_PICK)
                && (!r_found || (chk_pr > r_best_pri))) begin
            r_best_idx <= r_chk_idx;
            r_best_pri <= chk_pr;
        end
        if (i_cmd.push) begin
            r_ok <= push_ok;
        end
        if (i_cmd.best_commit && r_found) begin
            r_ok  <= 1'b1;
            r_res <= r_best_idx;
        end
        if (i_cmd.pop_commit) begin
            r_ok  <= 1'b1;
            r_res <= q_rdata;
        end
        if (i_cmd.out_load) begin
            o_ok           <= r_ok;
            o_result_index <= fps_pkg::IDX_W'(r_res);
            o_ready_count  <= fps_pkg::CNT_W'(r_count);
        end
    end

endmodule

`default_nettype wire

// ===== hdl/fps_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fps_checker (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      i_s_axis_tvalid,
    input wire logic                      o_s_axis_tready,
    input wire logic                      o_m_axis_tvalid,
    input wire logic                      i_m_axis_tready,
    input wire logic [fps_pkg::OUT_W-1:0] o_m_axis_tdata
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result changed while stalled");

    // one item in work at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("item accepted while another is in work");

    // a failed command reports index zero
    a_fail_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tdata[0] |-> o_m_axis_tdata[4:1] == 4'd0)
        else $error("nonzero index without ok");

    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result pending after reset");

endmodule

bind fifo_priority_task_scheduler fps_checker u_fps_checker (.*);

`default_nettype wire
